### hdl/qvr_pkg.sv
// Package of widths, types and limits for the quaternion vector rotation core.
`default_nettype none

package qvr_pkg;

   localparam int COMP_W     = 16;
   localparam int FRAC_SHIFT = 2 * (COMP_W - 2);
   localparam int PROD_W     = 2 * COMP_W;
   localparam int COEF_W     = PROD_W + 2;
   localparam int TERM_W     = COEF_W + COMP_W;
   localparam int SUM_W      = TERM_W + 2;
   localparam int NUM_STAGES = 5;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   localparam comp_type COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam comp_type COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
   } vec_type;

   // Pairwise products of the quaternion components.
   typedef struct packed {
      prod_type ww;
      prod_type aa;
      prod_type bb;
      prod_type cc;
      prod_type ab;
      prod_type wc;
      prod_type ac;
      prod_type wb;
      prod_type bc;
      prod_type wa;
   } prods_type;

   // Rotation matrix entries scaled by |q|^2; first letter is the output row.
   typedef struct packed {
      coef_type xx;
      coef_type xy;
      coef_type xz;
      coef_type yx;
      coef_type yy;
      coef_type yz;
      coef_type zx;
      coef_type zy;
      coef_type zz;
   } coefs_type;

   typedef struct packed {
      term_type xx;
      term_type xy;
      term_type xz;
      term_type yx;
      term_type yy;
      term_type yz;
      term_type zx;
      term_type zy;
      term_type zz;
   } terms_type;

   typedef struct packed {
      sum_type x;
      sum_type y;
      sum_type z;
   } sums_type;

endpackage

`default_nettype wire

### hdl/quaternion_vector_rotate_core.sv
// Pipelined rotation of a 3-vector by an unnormalized fixed-point quaternion.
`default_nettype none

// Each item carries a quaternion in signed Q1.14 and a signed 16-bit vector and
// returns the vector part of q*(0,v)*conj(q), so a non-unit quaternion also
// scales by |q|^2. The result is exact up to a floor shift by 28 and a clamp to
// the 16-bit range; saturated is set if any component was clamped. The core
// takes one item per clock while rsp_ready lets the pipeline move, and has five
// register stages: quaternion products, rotation matrix entries, nine
// matrix-by-vector multipliers, row sums, then shift and clamp into the output
// register. Each stage has its own valid bit and loads whenever it is empty or
// its successor moves, so bubbles are squeezed out while rsp_ready is low.
module quaternion_vector_rotate_core (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   output                     logic req_ready,
   input  wire  qvr_pkg::comp_type req_quat_w,
   input  wire  qvr_pkg::comp_type req_quat_i,
   input  wire  qvr_pkg::comp_type req_quat_j,
   input  wire  qvr_pkg::comp_type req_quat_k,
   input  wire  qvr_pkg::comp_type req_vec_x,
   input  wire  qvr_pkg::comp_type req_vec_y,
   input  wire  qvr_pkg::comp_type req_vec_z,
   output                     logic rsp_valid,
   input  wire                logic rsp_ready,
   output       qvr_pkg::comp_type rsp_rot_x,
   output       qvr_pkg::comp_type rsp_rot_y,
   output       qvr_pkg::comp_type rsp_rot_z,
   output                     logic rsp_saturated
);
   import qvr_pkg::*;

   typedef struct packed {
      comp_type value;
      logic     sat;
   } clamp_type;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] adv;

   prods_type prods_ff, prods_in;
   vec_type   vec0_ff;
   coefs_type coefs_ff, coefs_in;
   vec_type   vec1_ff;
   terms_type terms_ff, terms_in;
   sums_type  sums_ff, sums_in;
   vec_type   rot_ff, rot_in;
   logic      sat_ff, sat_in;

   function automatic coef_type diag(prod_type p0, prod_type p1, prod_type p2,
                                     prod_type p3);
      return COEF_W'(p0) + COEF_W'(p1) - COEF_W'(p2) - COEF_W'(p3);
   endfunction

   function automatic coef_type dbl_sum(prod_type pa, prod_type pb);
      coef_type s;
      s = COEF_W'(pa) + COEF_W'(pb);
      return s <<< 1;
   endfunction

   function automatic coef_type dbl_diff(prod_type pa, prod_type pb);
      coef_type d;
      d = COEF_W'(pa) - COEF_W'(pb);
      return d <<< 1;
   endfunction

   // Floor shift, then clamp when the bits above the sign do not all match it.
   function automatic clamp_type clamp(sum_type s);
      sum_type                  sh;
      logic [SUM_W-COMP_W:0]    hi;
      clamp_type                r;
      sh = s >>> FRAC_SHIFT;
      hi = sh[SUM_W-1:COMP_W-1];
      r.sat = ~((&hi) | ~(|hi));
      if (r.sat) begin
         r.value = sh[SUM_W-1] ? COMP_MIN : COMP_MAX;
      end else begin
         r.value = sh[COMP_W-1:0];
      end
      return r;
   endfunction

   // A stage loads when it is empty or its item moves on at the same edge.
   always_comb begin
      adv[NUM_STAGES-1] = ~valid_ff[NUM_STAGES-1] | rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = ~valid_ff[k] | adv[k+1];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_comb begin
      prods_in.ww = PROD_W'(req_quat_w) * PROD_W'(req_quat_w);
      prods_in.aa = PROD_W'(req_quat_i) * PROD_W'(req_quat_i);
      prods_in.bb = PROD_W'(req_quat_j) * PROD_W'(req_quat_j);
      prods_in.cc = PROD_W'(req_quat_k) * PROD_W'(req_quat_k);
      prods_in.ab = PROD_W'(req_quat_i) * PROD_W'(req_quat_j);
      prods_in.wc = PROD_W'(req_quat_w) * PROD_W'(req_quat_k);
      prods_in.ac = PROD_W'(req_quat_i) * PROD_W'(req_quat_k);
      prods_in.wb = PROD_W'(req_quat_w) * PROD_W'(req_quat_j);
      prods_in.bc = PROD_W'(req_quat_j) * PROD_W'(req_quat_k);
      prods_in.wa = PROD_W'(req_quat_w) * PROD_W'(req_quat_i);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prods_ff  <= prods_in;
         vec0_ff.x <= req_vec_x;
         vec0_ff.y <= req_vec_y;
         vec0_ff.z <= req_vec_z;
      end
   end

   always_comb begin
      coefs_in.xx = diag($signed(prods_ff.ww), $signed(prods_ff.aa),
                         $signed(prods_ff.bb), $signed(prods_ff.cc));
      coefs_in.yy = diag($signed(prods_ff.ww), $signed(prods_ff.bb),
                         $signed(prods_ff.aa), $signed(prods_ff.cc));
      coefs_in.zz = diag($signed(prods_ff.ww), $signed(prods_ff.cc),
                         $signed(prods_ff.aa), $signed(prods_ff.bb));
      coefs_in.xy = dbl_diff($signed(prods_ff.ab), $signed(prods_ff.wc));
      coefs_in.xz = dbl_sum($signed(prods_ff.ac), $signed(prods_ff.wb));
      coefs_in.yx = dbl_sum($signed(prods_ff.ab), $signed(prods_ff.wc));
      coefs_in.yz = dbl_diff($signed(prods_ff.bc), $signed(prods_ff.wa));
      coefs_in.zx = dbl_diff($signed(prods_ff.ac), $signed(prods_ff.wb));
      coefs_in.zy = dbl_sum($signed(prods_ff.bc), $signed(prods_ff.wa));
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         coefs_ff <= coefs_in;
         vec1_ff  <= vec0_ff;
      end
   end

   always_comb begin
      terms_in.xx = TERM_W'($signed(coefs_ff.xx)) * TERM_W'($signed(vec1_ff.x));
      terms_in.xy = TERM_W'($signed(coefs_ff.xy)) * TERM_W'($signed(vec1_ff.y));
      terms_in.xz = TERM_W'($signed(coefs_ff.xz)) * TERM_W'($signed(vec1_ff.z));
      terms_in.yx = TERM_W'($signed(coefs_ff.yx)) * TERM_W'($signed(vec1_ff.x));
      terms_in.yy = TERM_W'($signed(coefs_ff.yy)) * TERM_W'($signed(vec1_ff.y));
      terms_in.yz = TERM_W'($signed(coefs_ff.yz)) * TERM_W'($signed(vec1_ff.z));
      terms_in.zx = TERM_W'($signed(coefs_ff.zx)) * TERM_W'($signed(vec1_ff.x));
      terms_in.zy = TERM_W'($signed(coefs_ff.zy)) * TERM_W'($signed(vec1_ff.y));
      terms_in.zz = TERM_W'($signed(coefs_ff.zz)) * TERM_W'($signed(vec1_ff.z));
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         terms_ff <= terms_in;
      end
   end

   always_comb begin
      sums_in.x = SUM_W'($signed(terms_ff.xx)) + SUM_W'($signed(terms_ff.xy))
                + SUM_W'($signed(terms_ff.xz));
      sums_in.y = SUM_W'($signed(terms_ff.yx)) + SUM_W'($signed(terms_ff.yy))
                + SUM_W'($signed(terms_ff.yz));
      sums_in.z = SUM_W'($signed(terms_ff.zx)) + SUM_W'($signed(terms_ff.zy))
                + SUM_W'($signed(terms_ff.zz));
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         sums_ff <= sums_in;
      end
   end

   clamp_type clamp_x, clamp_y, clamp_z;

   always_comb begin
      clamp_x  = clamp($signed(sums_ff.x));
      clamp_y  = clamp($signed(sums_ff.y));
      clamp_z  = clamp($signed(sums_ff.z));
      rot_in.x = clamp_x.value;
      rot_in.y = clamp_y.value;
      rot_in.z = clamp_z.value;
      sat_in   = clamp_x.sat | clamp_y.sat | clamp_z.sat;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff[NUM_STAGES-1];
   assign rsp_rot_x     = rot_ff.x;
   assign rsp_rot_y     = rot_ff.y;
   assign rsp_rot_z     = rot_ff.z;
   assign rsp_saturated = sat_ff;

   // An accepted item always lands in the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted item did not enter the pipeline");

   // A held item is never dropped while its successor is stalled.
   a_stall_keeps_stage1: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !adv[2] |=> valid_ff[1])
      else $error("stalled item lost in stage 1");

   a_stall_keeps_stage3: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !adv[4] |=> valid_ff[3])
      else $error("stalled item lost in stage 3");

   // An empty pipeline must accept.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      valid_ff == '0 |-> req_ready)
      else $error("empty pipeline refused an item");

   // A clamped result shows at least one component at a range limit.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_rot_x == COMP_MAX || rsp_rot_x == COMP_MIN ||
          rsp_rot_y == COMP_MAX || rsp_rot_y == COMP_MIN ||
          rsp_rot_z == COMP_MAX || rsp_rot_z == COMP_MIN))
      else $error("saturated flag set without a clamped component");

endmodule

`default_nettype wire

### dv/tb_quaternion_vector_rotate_core.sv
// Self-checking testbench for the quaternion vector rotation core with random handshake stalls.
`default_nettype none

module tb_quaternion_vector_rotate_core;
   timeunit 1ns;
   timeprecision 1ps;

   import qvr_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 2 * NUM_STAGES;
   localparam int DIR_ROWS = 20;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      logic     sat;
   } rot_result_type;

   typedef struct packed {
      comp_type       w;
      comp_type       i;
      comp_type       j;
      comp_type       k;
      comp_type       x;
      comp_type       y;
      comp_type       z;
      logic           typed;
      rot_result_type want;
   } dir_row_type;

   // Rows with typed = 1 carry a hand-computed result; the rest use the predictor.
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // Zero quaternion wipes the vector out.
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h1234,
        1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      // Identity passes the vector through.
      '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
        1'b1, '{16'h0001, 16'hFFFF, 16'h7FFF, 1'b0}},
      '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h1234,
        1'b1, '{16'h8000, 16'h0000, 16'h1234, 1'b0}},
      '{16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'hEDCC, 16'h0042,
        1'b1, '{16'h1234, 16'hEDCC, 16'h0042, 1'b0}},
      // Half turns about each axis.
      '{16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0003, 16'h0002, 16'h0001,
        1'b1, '{16'h0003, 16'hFFFE, 16'hFFFF, 1'b0}},
      '{16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0003, 16'h0002, 16'h0001,
        1'b1, '{16'hFFFD, 16'h0002, 16'hFFFF, 1'b0}},
      '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0003, 16'h0002, 16'h0001,
        1'b1, '{16'hFFFD, 16'hFFFE, 16'h0001, 1'b0}},
      // A norm of four pushes both ends of the range into the clamp.
      '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000,
        1'b1, '{16'h7FFF, 16'h8000, 16'h0000, 1'b1}},
      '{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000,
        1'b1, '{16'h7FFF, 16'h0000, 16'h0000, 1'b1}},
      // A quarter of the scale shows the floor on negative values.
      '{16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFB,
        1'b1, '{16'hFFFF, 16'h0000, 16'hFFFE, 1'b0}},
      '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
        1'b1, '{16'h8000, 16'h8000, 16'h8000, 1'b0}},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
        1'b0, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        1'b0, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{16'h2D41, 16'h0000, 16'h0000, 16'h2D41, 16'h1000, 16'h0000, 16'h0000,
        1'b0, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{16'h2D41, 16'h2D41, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000,
        1'b0, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
        1'b0, '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
        1'b1, '{16'h0000, 16'hFFFC, 16'h0000, 1'b0}},
      // Landing exactly on the minimum is not a clamp, one step past the maximum is.
      '{16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h2000,
        1'b1, '{16'h0000, 16'h0000, 16'h8000, 1'b0}},
      '{16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'hE000,
        1'b1, '{16'h0000, 16'h0000, 16'h7FFF, 1'b1}},
      '{16'h1234, 16'hDCBA, 16'h0F0F, 16'hF0F0, 16'h5A5A, 16'hA5A5, 16'h3C3C,
        1'b0, '{16'h0000, 16'h0000, 16'h0000, 1'b0}}
   };

   logic     clock;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   comp_type req_quat_w = '0;
   comp_type req_quat_i = '0;
   comp_type req_quat_j = '0;
   comp_type req_quat_k = '0;
   comp_type req_vec_x = '0;
   comp_type req_vec_y = '0;
   comp_type req_vec_z = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   comp_type rsp_rot_x;
   comp_type rsp_rot_y;
   comp_type rsp_rot_z;
   logic     rsp_saturated;

   // Hand-computed result that travels with the item on the request side.
   logic           item_typed = 1'b0;
   rot_result_type item_typed_rot = '0;

   rot_result_type rotations_due [$];
   int             error_count = 0;
   int             items_sent = 0;
   int             results_checked = 0;
   int             clamps_seen = 0;
   int             quiet_cycles = 0;
   bit             idle_on = 1'b1;
   bit             stall_on = 1'b1;

   quaternion_vector_rotate_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_quat_w    (req_quat_w),
      .req_quat_i    (req_quat_i),
      .req_quat_j    (req_quat_j),
      .req_quat_k    (req_quat_k),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rot_x     (rsp_rot_x),
      .rsp_rot_y     (rsp_rot_y),
      .rsp_rot_z     (rsp_rot_z),
      .rsp_saturated (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor shift of the exact sum, then clamp; bit 16 of the return flags a clamp.
   function automatic logic [COMP_W:0] clamp_lane(longint sum);
      longint scaled;
      scaled = sum >>> FRAC_SHIFT;
      if (scaled > longint'(COMP_MAX)) return {1'b1, COMP_MAX};
      if (scaled < longint'(COMP_MIN)) return {1'b1, COMP_MIN};
      return {1'b0, comp_type'(scaled)};
   endfunction

   // Vector part of q*(0,v)*conj(q), written as the |q|^2-scaled rotation matrix.
   function automatic rot_result_type rotate_vector(comp_type qw, comp_type qi,
                                                    comp_type qj, comp_type qk,
                                                    comp_type vx, comp_type vy,
                                                    comp_type vz);
      longint w, a, b, c, x, y, z;
      longint sx, sy, sz;
      logic [COMP_W:0] lx, ly, lz;
      rot_result_type r;
      w = longint'(qw); a = longint'(qi); b = longint'(qj); c = longint'(qk);
      x = longint'(vx); y = longint'(vy); z = longint'(vz);
      sx = (w*w + a*a - b*b - c*c) * x + 2 * (a*b - w*c) * y + 2 * (a*c + w*b) * z;
      sy = 2 * (a*b + w*c) * x + (w*w - a*a + b*b - c*c) * y + 2 * (b*c - w*a) * z;
      sz = 2 * (a*c - w*b) * x + 2 * (b*c + w*a) * y + (w*w - a*a - b*b + c*c) * z;
      lx = clamp_lane(sx);
      ly = clamp_lane(sy);
      lz = clamp_lane(sz);
      r.x = lx[COMP_W-1:0];
      r.y = ly[COMP_W-1:0];
      r.z = lz[COMP_W-1:0];
      r.sat = lx[COMP_W] | ly[COMP_W] | lz[COMP_W];
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly random, sometimes one of the range corners.
   function automatic comp_type pick_comp();
      case ($urandom_range(0, 19))
         0: return COMP_MAX;
         1: return COMP_MIN;
         2: return '0;
         3: return '1;
         default: return comp_type'($urandom);
      endcase
   endfunction

   task automatic report_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_item(comp_type w, comp_type i, comp_type j, comp_type k,
                            comp_type x, comp_type y, comp_type z,
                            logic typed, rot_result_type typed_rot);
      int g;
      req_valid <= 1'b1;
      req_quat_w <= w;
      req_quat_i <= i;
      req_quat_j <= j;
      req_quat_k <= k;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      item_typed <= typed;
      item_typed_rot <= typed_rot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      g = gap_len();
      if (idle_on && g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Hold the sender off until the pipeline has handed back every item.
   task automatic drain_rotations();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rotations_due.size() != 0) @(posedge clock);
   endtask

   // Result side: runs of ready with random stalls in between.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         int g;
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         g = gap_len();
         if (stall_on && g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rot_result_type want;
      rot_result_type due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (item_typed)
               due = item_typed_rot;
            else
               due = rotate_vector(req_quat_w, req_quat_i, req_quat_j,
                                   req_quat_k, req_vec_x, req_vec_y, req_vec_z);
            rotations_due = {rotations_due, due};
         end
         if (rsp_valid && rsp_ready) begin
            if (rotations_due.size() == 0) begin
               report_error("result arrived with no item outstanding");
            end else begin
               want = rotations_due.pop_front();
               results_checked++;
               if (rsp_saturated) clamps_seen++;
               if (rsp_rot_x !== want.x)
                  report_error($sformatf("rot_x got %0d want %0d", rsp_rot_x, want.x));
               if (rsp_rot_y !== want.y)
                  report_error($sformatf("rot_y got %0d want %0d", rsp_rot_y, want.y));
               if (rsp_rot_z !== want.z)
                  report_error($sformatf("rot_z got %0d want %0d", rsp_rot_z, want.z));
               if (rsp_saturated !== want.sat)
                  report_error($sformatf("saturated got %b want %b", rsp_saturated,
                                         want.sat));
            end
         end
      end
   end

   // Watchdog on cycles where neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int             phase_items [3];
      comp_type       q [4];
      int             sel;
      rot_result_type no_rot;
      phase_items = '{300, 700, 630};
      no_rot = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_TABLE[n])
         send_item(DIR_TABLE[n].w, DIR_TABLE[n].i, DIR_TABLE[n].j, DIR_TABLE[n].k,
                   DIR_TABLE[n].x, DIR_TABLE[n].y, DIR_TABLE[n].z,
                   DIR_TABLE[n].typed, DIR_TABLE[n].want);
      drain_rotations();

      // First phase streams back to back, later ones idle on both sides.
      for (int p = 0; p < 3; p++) begin
         idle_on = (p != 0);
         stall_on = (p != 0);
         for (int n = 0; n < phase_items[p]; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
               // Quaternion near unit scale, the usual case for a rotation.
               foreach (q[m]) q[m] = comp_type'(int'($urandom_range(0, 32768)) - 16384);
            end else if (sel < 8) begin
               foreach (q[m]) q[m] = pick_comp();
            end else begin
               foreach (q[m]) q[m] = '0;
               q[$urandom_range(0, 3)] = pick_comp();
            end
            send_item(q[0], q[1], q[2], q[3], pick_comp(), pick_comp(), pick_comp(),
                      1'b0, no_rot);
         end
         drain_rotations();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d directed, rest random) with gaps and stalls.",
               items_sent, DIR_ROWS);
      $display("Checked %0d results, %0d of them clamped.", results_checked, clamps_seen);
      if (error_count == 0 && rotations_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors, %0d results missing", error_count, rotations_due.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
hdl/qvr_pkg.sv
hdl/quaternion_vector_rotate_core.sv
dv/tb_quaternion_vector_rotate_core.sv
